FILE: rtl/tun_pkg.sv
package tun_pkg;

	localparam int CoordW = 24;
	localparam int EdgeW  = 25;
	localparam int CrossW = 50;
	localparam int MagW   = 49;
	localparam int SqW    = 98;
	localparam int SumW   = 100;
	localparam int RootW  = 50;
	localparam int FracW  = 30;
	localparam int QuotW  = 31;
	localparam int NumW   = MagW + FracW;
	localparam int OutW   = 32;

	typedef struct packed {
		logic signed [CoordW-1:0] ax;
		logic signed [CoordW-1:0] ay;
		logic signed [CoordW-1:0] az;
		logic signed [CoordW-1:0] bx;
		logic signed [CoordW-1:0] by_coord;
		logic signed [CoordW-1:0] bz;
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic signed [CoordW-1:0] cz;
	} tri_in_t;

	typedef struct packed {
		logic signed [OutW-1:0] nx;
		logic signed [OutW-1:0] ny;
		logic signed [OutW-1:0] nz;
		logic                   degenerate;
	} norm_out_t;

	typedef struct packed {
		logic [2:0]          neg;
		logic [2:0][MagW-1:0] m;
	} mag_t;

endpackage

FILE: rtl/triangle_unit_normal.sv
// Triangle unit normal, fully pipelined.
// Input: assert start with tri for one cycle; a beat is taken when start is
// high and busy is low. busy is held low, so a new triangle may enter in
// every cycle.
// Output: each triangle yields one result beat, shown on result for exactly
// one cycle with done high. The receiver cannot stall; results leave in
// input order.
// Pipeline: cross product, squared length, square root (one root bit per
// stage), then scaled division (one quotient bit per stage, all three lanes
// in parallel) and the output register that drives done and result.
// Throughput: one triangle per cycle, set by the one-bit-per-stage root and
// divide pipelines.
// Reset: arst_n clears all valid bits; no beats are in flight afterward.
// A zero-length normal gives zero components with degenerate set.
module triangle_unit_normal (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tun_pkg::tri_in_t    tri_in,
	output logic                done,
	output tun_pkg::norm_out_t  result
);
	import tun_pkg::*;

	logic             v_x, v_q, v_r;
	mag_t             mag_x, mag_q, mag_r;
	logic [SumW-1:0]  sum_q;
	logic [RootW-1:0] root_r;

	assign busy = 1'b0;

	tun_cross u_cross (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .in_tri(tri_in),
		.out_valid(v_x), .out_mag(mag_x)
	);

	tun_sqsum u_sqsum (
		.clk(clk), .arst_n(arst_n), .in_valid(v_x), .in_mag(mag_x),
		.out_valid(v_q), .out_mag(mag_q), .sum(sum_q)
	);

	tun_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(v_q), .in_mag(mag_q), .in_sum(sum_q),
		.out_valid(v_r), .out_mag(mag_r), .root(root_r)
	);

	tun_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_r), .in_mag(mag_r), .in_root(root_r),
		.out_valid(done), .out_res(result)
	);

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |-> result.nx == 0 && result.ny == 0 && result.nz == 0)
		else $error("degenerate result with nonzero normal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.nx <= 32'sd1073741824 && result.nx >= -32'sd1073741824)
		else $error("normal x out of range");

	a_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_r && root_r == 0 |-> mag_r.m[0] == 0 && mag_r.m[1] == 0 && mag_r.m[2] == 0)
		else $error("zero root with nonzero cross product");
endmodule

FILE: rtl/tun_cross.sv
module tun_cross (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  tun_pkg::tri_in_t in_tri,
	output logic            out_valid,
	output tun_pkg::mag_t   out_mag
);
	import tun_pkg::*;

	logic signed [EdgeW-1:0] e1_s1 [3];
	logic signed [EdgeW-1:0] e2_s1 [3];
	logic                    v_s1;
	logic signed [CrossW-1:0] p_s2 [6];
	logic                    v_s2;
	logic signed [CrossW-1:0] n_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		e1_s1[0] <= EdgeW'(in_tri.bx) - EdgeW'(in_tri.ax);
		e1_s1[1] <= EdgeW'(in_tri.by_coord) - EdgeW'(in_tri.ay);
		e1_s1[2] <= EdgeW'(in_tri.bz) - EdgeW'(in_tri.az);
		e2_s1[0] <= EdgeW'(in_tri.cx) - EdgeW'(in_tri.ax);
		e2_s1[1] <= EdgeW'(in_tri.cy) - EdgeW'(in_tri.ay);
		e2_s1[2] <= EdgeW'(in_tri.cz) - EdgeW'(in_tri.az);
		p_s2[0] <= CrossW'(e1_s1[1] * e2_s1[2]);
		p_s2[1] <= CrossW'(e1_s1[2] * e2_s1[1]);
		p_s2[2] <= CrossW'(e1_s1[2] * e2_s1[0]);
		p_s2[3] <= CrossW'(e1_s1[0] * e2_s1[2]);
		p_s2[4] <= CrossW'(e1_s1[0] * e2_s1[1]);
		p_s2[5] <= CrossW'(e1_s1[1] * e2_s1[0]);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_c[i] = p_s2[2*i] - p_s2[2*i+1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			out_mag.neg[i] <= n_c[i][CrossW-1];
			out_mag.m[i] <= n_c[i][CrossW-1] ? MagW'(-n_c[i]) : MagW'(n_c[i]);
		end
	end
endmodule

FILE: rtl/tun_sqsum.sv
module tun_sqsum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  tun_pkg::mag_t               in_mag,
	output logic                        out_valid,
	output tun_pkg::mag_t               out_mag,
	output logic [tun_pkg::SumW-1:0]    sum
);
	import tun_pkg::*;

	localparam int HalfW = 25;
	localparam int LoW   = MagW - HalfW;

	logic [2*HalfW-1:0] pp_s1 [3][4];
	mag_t               m_s1;
	logic               v_s1;
	logic [SqW-1:0]     sq_s2 [3];
	mag_t               m_s2;
	logic               v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		m_s1 <= in_mag;
		m_s2 <= m_s1;
		out_mag <= m_s2;
		for (int i = 0; i < 3; i++) begin
			pp_s1[i][0] <= (2*HalfW)'(in_mag.m[i][LoW-1:0]) * (2*HalfW)'(in_mag.m[i][LoW-1:0]);
			pp_s1[i][1] <= (2*HalfW)'(in_mag.m[i][LoW-1:0]) * (2*HalfW)'(in_mag.m[i][MagW-1:LoW]);
			pp_s1[i][2] <= (2*HalfW)'(in_mag.m[i][MagW-1:LoW]) * (2*HalfW)'(in_mag.m[i][LoW-1:0]);
			pp_s1[i][3] <= (2*HalfW)'(in_mag.m[i][MagW-1:LoW]) * (2*HalfW)'(in_mag.m[i][MagW-1:LoW]);
			sq_s2[i] <= SqW'(pp_s1[i][0]) + (SqW'(pp_s1[i][1]) << LoW)
				+ (SqW'(pp_s1[i][2]) << LoW) + (SqW'(pp_s1[i][3]) << (2*LoW));
		end
		sum <= SumW'(sq_s2[0]) + SumW'(sq_s2[1]) + SumW'(sq_s2[2]);
	end
endmodule

FILE: rtl/tun_isqrt.sv
module tun_isqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  tun_pkg::mag_t            in_mag,
	input  logic [tun_pkg::SumW-1:0] in_sum,
	output logic                     out_valid,
	output tun_pkg::mag_t            out_mag,
	output logic [tun_pkg::RootW-1:0] root
);
	import tun_pkg::*;

	localparam int Steps = RootW;
	localparam int RemW  = RootW + 2;

	logic [Steps:0]          v_p;
	logic [SumW-1:0]         x_p [Steps+1];
	logic [RemW-1:0]         r_p [Steps+1];
	logic [RootW-1:0]        q_p [Steps+1];
	mag_t                    m_p [Steps+1];

	assign v_p[0] = in_valid;
	assign x_p[0] = in_sum;
	assign r_p[0] = '0;
	assign q_p[0] = '0;
	assign m_p[0] = in_mag;

	for (genvar k = 0; k < Steps; k++) begin : g_step
		logic [RemW-1:0] rem_c;
		logic [RemW-1:0] trial_c;
		always_comb begin
			rem_c   = {r_p[k][RemW-3:0], x_p[k][SumW-1:SumW-2]};
			trial_c = {q_p[k], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[k+1] <= 1'b0;
			end else begin
				v_p[k+1] <= v_p[k];
			end
		end
		always_ff @(posedge clk) begin
			x_p[k+1] <= x_p[k] << 2;
			m_p[k+1] <= m_p[k];
			if (rem_c >= trial_c) begin
				r_p[k+1] <= rem_c - trial_c;
				q_p[k+1] <= {q_p[k][RootW-2:0], 1'b1};
			end else begin
				r_p[k+1] <= rem_c;
				q_p[k+1] <= {q_p[k][RootW-2:0], 1'b0};
			end
		end
	end

	assign out_valid = v_p[Steps];
	assign out_mag   = m_p[Steps];
	assign root      = q_p[Steps];
endmodule

FILE: rtl/tun_div.sv
module tun_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  tun_pkg::mag_t             in_mag,
	input  logic [tun_pkg::RootW-1:0] in_root,
	output logic                      out_valid,
	output tun_pkg::norm_out_t        out_res
);
	import tun_pkg::*;

	localparam int RemW = RootW + 1;

	logic [QuotW:0]   v_p;
	logic [NumW-1:0]  n_p [QuotW+1][3];
	logic [RemW-1:0]  r_p [QuotW+1][3];
	logic [QuotW-1:0] q_p [QuotW+1][3];
	logic [2:0]       s_p [QuotW+1];
	logic [RootW-1:0] d_p [QuotW+1];

	assign v_p[0] = in_valid;
	assign s_p[0] = in_mag.neg;
	assign d_p[0] = in_root;
	for (genvar i = 0; i < 3; i++) begin : g_init
		assign n_p[0][i] = {in_mag.m[i], {FracW{1'b0}}} << (NumW - QuotW);
		assign r_p[0][i] = RemW'(in_mag.m[i] >> (MagW - (NumW - QuotW)));
		assign q_p[0][i] = '0;
	end

	for (genvar k = 0; k < QuotW; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[k+1] <= 1'b0;
			end else begin
				v_p[k+1] <= v_p[k];
			end
		end
		always_ff @(posedge clk) begin
			s_p[k+1] <= s_p[k];
			d_p[k+1] <= d_p[k];
		end
		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [RemW-1:0] rem_c;
			always_comb begin
				rem_c = {r_p[k][i][RemW-2:0], n_p[k][i][NumW-1]};
			end
			always_ff @(posedge clk) begin
				n_p[k+1][i] <= n_p[k][i] << 1;
				if (rem_c >= RemW'(d_p[k])) begin
					r_p[k+1][i] <= rem_c - RemW'(d_p[k]);
					q_p[k+1][i] <= {q_p[k][i][QuotW-2:0], 1'b1};
				end else begin
					r_p[k+1][i] <= rem_c;
					q_p[k+1][i] <= {q_p[k][i][QuotW-2:0], 1'b0};
				end
			end
		end
	end

	logic deg_c;
	assign deg_c = (d_p[QuotW] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_p[QuotW];
		end
	end

	always_ff @(posedge clk) begin
		out_res.degenerate <= deg_c;
		out_res.nx <= deg_c ? '0 : (s_p[QuotW][0] ? -OutW'(q_p[QuotW][0]) : OutW'(q_p[QuotW][0]));
		out_res.ny <= deg_c ? '0 : (s_p[QuotW][1] ? -OutW'(q_p[QuotW][1]) : OutW'(q_p[QuotW][1]));
		out_res.nz <= deg_c ? '0 : (s_p[QuotW][2] ? -OutW'(q_p[QuotW][2]) : OutW'(q_p[QuotW][2]));
	end
endmodule

FILE: tb/sv/triangle_unit_normal_tb.sv
`timescale 1ns / 100ps

module triangle_unit_normal_tb;
	import tun_pkg::*;

	localparam int MaxC = 8388607;
	localparam int MinC = -8388608;

	class normal_board;
		norm_out_t expected_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function norm_out_t compute_normal(tri_in_t t);
			longint e1[3], e2[3], n[3];
			logic [127:0] sq_len;
			logic [63:0] len, q, c, mg;
			logic [31:0] comp[3];
			norm_out_t r;
			int i, b;
			e1[0] = longint'($signed(t.bx)) - longint'($signed(t.ax));
			e1[1] = longint'($signed(t.by_coord)) - longint'($signed(t.ay));
			e1[2] = longint'($signed(t.bz)) - longint'($signed(t.az));
			e2[0] = longint'($signed(t.cx)) - longint'($signed(t.ax));
			e2[1] = longint'($signed(t.cy)) - longint'($signed(t.ay));
			e2[2] = longint'($signed(t.cz)) - longint'($signed(t.az));
			n[0] = e1[1] * e2[2] - e1[2] * e2[1];
			n[1] = e1[2] * e2[0] - e1[0] * e2[2];
			n[2] = e1[0] * e2[1] - e1[1] * e2[0];
			sq_len = '0;
			for (i = 0; i < 3; i++) begin
				mg = (n[i] < 0) ? -n[i] : n[i];
				sq_len += 128'(mg) * 128'(mg);
			end
			len = '0;
			for (b = 51; b >= 0; b--) begin
				c = len | (64'd1 << b);
				if (128'(c) * 128'(c) <= sq_len)
					len = c;
			end
			r = '0;
			if (len == 0) begin
				r.degenerate = 1'b1;
				return r;
			end
			for (i = 0; i < 3; i++) begin
				mg = (n[i] < 0) ? -n[i] : n[i];
				q = '0;
				for (b = FracW; b >= 0; b--) begin
					c = q | (64'd1 << b);
					if (128'(c) * 128'(len) <= (128'(mg) << FracW))
						q = c;
				end
				if (n[i] < 0)
					q = -q;
				comp[i] = q[31:0];
			end
			r.nx = comp[0];
			r.ny = comp[1];
			r.nz = comp[2];
			return r;
		endfunction

		function void note_triangle(tri_in_t t);
			expected_q.push_back(compute_normal(t));
		endfunction

		function void check_normal(norm_out_t got);
			norm_out_t exp_n;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			exp_n = expected_q.pop_front();
			if (got.nx !== exp_n.nx) begin
				$display("%0t: nx expected %0d actual %0d", $time, exp_n.nx, got.nx);
				errors++;
			end
			if (got.ny !== exp_n.ny) begin
				$display("%0t: ny expected %0d actual %0d", $time, exp_n.ny, got.ny);
				errors++;
			end
			if (got.nz !== exp_n.nz) begin
				$display("%0t: nz expected %0d actual %0d", $time, exp_n.nz, got.nz);
				errors++;
			end
			if (got.degenerate !== exp_n.degenerate) begin
				$display("%0t: degenerate expected %0b actual %0b", $time,
					exp_n.degenerate, got.degenerate);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	tri_in_t   tri_in;
	logic      done;
	norm_out_t result;

	normal_board board = new();

	triangle_unit_normal u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.tri_in(tri_in),
		.done(done),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			board.note_triangle(tri_in);
		if (arst_n && done)
			board.check_normal(result);
	end

	task automatic send_triangle(tri_in_t t);
		int gap;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		tri_in <= t;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_coord(int kind);
		case (kind)
			0: return 24'($urandom_range(0, 15)) - 24'd8;
			1: return 24'($urandom_range(0, 2047)) - 24'd1024;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic tri_in_t rand_triangle();
		tri_in_t t;
		int kind, mode;
		logic signed [23:0] k;
		kind = $urandom_range(0, 2);
		mode = $urandom_range(0, 9);
		t.ax = rand_coord(kind);
		t.ay = rand_coord(kind);
		t.az = rand_coord(kind);
		t.bx = rand_coord(kind);
		t.by_coord = rand_coord(kind);
		t.bz = rand_coord(kind);
		t.cx = rand_coord(kind);
		t.cy = rand_coord(kind);
		t.cz = rand_coord(kind);
		if (mode == 0) begin
			k = 24'($urandom_range(0, 6)) - 24'd3;
			t.ax = rand_coord(0);
			t.ay = rand_coord(0);
			t.az = rand_coord(0);
			t.bx = t.ax + rand_coord(0);
			t.by_coord = t.ay + rand_coord(0);
			t.bz = t.az + rand_coord(0);
			t.cx = t.ax + k * (t.bx - t.ax);
			t.cy = t.ay + k * (t.by_coord - t.ay);
			t.cz = t.az + k * (t.bz - t.az);
		end else if (mode == 1) begin
			t.cx = t.ax;
			t.cy = t.ay;
			t.cz = t.az;
		end
		return t;
	endfunction

	function automatic tri_in_t make_tri(int a0, int a1, int a2, int b0, int b1, int b2,
		int c0, int c1, int c2);
		tri_in_t t;
		t.ax = a0[23:0];
		t.ay = a1[23:0];
		t.az = a2[23:0];
		t.bx = b0[23:0];
		t.by_coord = b1[23:0];
		t.bz = b2[23:0];
		t.cx = c0[23:0];
		t.cy = c1[23:0];
		t.cz = c2[23:0];
		return t;
	endfunction

	initial begin
		start  <= 1'b0;
		tri_in <= '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
		send_triangle(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
		send_triangle(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
		send_triangle(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
		send_triangle(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
		send_triangle(make_tri(5, 5, 5, 5, 5, 5, 9, -3, 7));
		send_triangle(make_tri(MinC, MinC, MinC, MaxC, MinC, MinC, MinC, MaxC, MinC));
		send_triangle(make_tri(MinC, MinC, MinC, MaxC, MaxC, MinC, MinC, MaxC, MaxC));
		send_triangle(make_tri(MaxC, MaxC, MaxC, MinC, MaxC, MinC, MaxC, MinC, MinC));
		send_triangle(make_tri(MinC, MaxC, MinC, MaxC, MinC, MaxC, MaxC, MaxC, MinC));
		send_triangle(make_tri(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC));
		send_triangle(make_tri(MinC, MinC, MinC, MaxC, MaxC, MaxC, MinC, MinC, MinC));
		send_triangle(make_tri(-1, -1, -1, 0, 0, 0, 1, -1, 1));
		send_triangle(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 5));
		send_triangle(make_tri(0, 0, 0, 1, 1, 1, -1, 2, -1));
		drain_results();

		for (int i = 0; i < 1850; i++) begin
			if (i == 900)
				drain_results();
			if (i >= 1200 && i < 1400) begin
				start  <= 1'b1;
				tri_in <= rand_triangle();
				do @(posedge clk); while (busy);
			end else
				send_triangle(rand_triangle());
		end
		start <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0)
			$display("triangle_unit_normal_tb: clean");
		else
			$display("triangle_unit_normal_tb: errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("triangle_unit_normal_tb: errors");
		$finish;
	end

endmodule

FILE: triangle_unit_normal.f
rtl/tun_pkg.sv
rtl/tun_cross.sv
rtl/tun_sqsum.sv
rtl/tun_isqrt.sv
rtl/tun_div.sv
rtl/triangle_unit_normal.sv
tb/sv/triangle_unit_normal_tb.sv
